// ===== hw/rtl/ccs_pkg.sv =====
// Shared types and constants for the comment stripper.
package ccs_pkg;

    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_NL    = 8'h0A;

    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_SLASH  = 3'd1,
        MODE_LINE   = 3'd2,
        MODE_BLOCK  = 3'd3,
        MODE_STAR   = 3'd4
    } scan_mode_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } src_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       out_last;
    } dst_item_t;

    typedef struct packed {
        logic [1:0] count;
        dst_item_t  item0;
        dst_item_t  item1;
    } scan_result_t;

endpackage

// ===== hw/rtl/ccs_out_queue.sv =====
// Result queue that takes up to two items per cycle and hands out one while dst_stall is low.
module ccs_out_queue #(
    parameter int Depth = ccs_pkg::QUEUE_DEPTH
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  ccs_pkg::scan_result_t   push_data,
    output logic                    room,
    output logic                    dst_valid,
    input  logic                    dst_stall,
    output ccs_pkg::dst_item_t      dst_data
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] RoomMax = CntW'(Depth - 2);

    ccs_pkg::dst_item_t mem [Depth];

    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;
    logic [PtrW-1:0] wr_ptr_plus1;
    logic [PtrW-1:0] wr_ptr_plus2;
    logic [1:0]      push_n;
    logic            pop;

    assign wr_ptr_plus1 = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + PtrW'(1);
    assign wr_ptr_plus2 = (wr_ptr_plus1 == LastPtr) ? '0 : wr_ptr_plus1 + PtrW'(1);
    assign push_n       = push ? push_data.count : 2'd0;
    assign pop          = dst_valid && !dst_stall;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        if (push_n == 2'd1)
        begin
            wr_ptr_next = wr_ptr_plus1;
        end
        else if (push_n == 2'd2)
        begin
            wr_ptr_next = wr_ptr_plus2;
        end
        rd_ptr_next = rd_ptr_reg;
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + PtrW'(1);
        end
        count_next = count_reg + CntW'(push_n) - CntW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            mem[wr_ptr_reg] <= push_data.item0;
        end
        if (push_n == 2'd2)
        begin
            mem[wr_ptr_plus1] <= push_data.item1;
        end
    end

    assign room      = (count_reg <= RoomMax);
    assign dst_valid = (count_reg != '0);
    assign dst_data  = mem[rd_ptr_reg];

endmodule

// ===== hw/rtl/c_comment_stripper.sv =====
// Top level of the C-style comment stripper.
// The block passes on every source byte outside // and /* */ comments, one
// source byte per cycle while src_stall is low. Each source byte is decoded
// combinationally against the scan mode and its zero, one or two results go
// straight into a small result queue of Depth entries; the queue takes a new
// byte whenever at least two entries are free, so with the default depth the
// input runs at one byte per clock as long as the output side keeps up. A
// slash followed by an ordinary byte yields two results, which enter the
// queue together and leave it one at a time. After the last byte the final
// result carries out_last, or an item with out_last alone is given.
module c_comment_stripper #(
    parameter int Depth = ccs_pkg::QUEUE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                src_valid,
    output logic                src_stall,
    input  ccs_pkg::src_item_t  src_data,
    output logic                dst_valid,
    input  logic                dst_stall,
    output ccs_pkg::dst_item_t  dst_data
);

    ccs_pkg::scan_mode_t   mode_reg, mode_next, mode_step;
    ccs_pkg::scan_result_t result;
    logic                  src_xfer;
    logic                  room;
    logic [7:0]            b;

    assign b         = src_data.in_byte;
    assign src_stall = !room;
    assign src_xfer  = src_valid && room;

    always_comb
    begin
        mode_step = ccs_pkg::MODE_NORMAL;
        unique case (mode_reg)
            ccs_pkg::MODE_SLASH:
            begin
                if (b == ccs_pkg::CH_SLASH)
                    mode_step = ccs_pkg::MODE_LINE;
                else if (b == ccs_pkg::CH_STAR)
                    mode_step = ccs_pkg::MODE_BLOCK;
                else
                    mode_step = ccs_pkg::MODE_NORMAL;
            end
            ccs_pkg::MODE_LINE:
            begin
                mode_step = (b == ccs_pkg::CH_NL) ? ccs_pkg::MODE_NORMAL
                                                  : ccs_pkg::MODE_LINE;
            end
            ccs_pkg::MODE_BLOCK:
            begin
                mode_step = (b == ccs_pkg::CH_STAR) ? ccs_pkg::MODE_STAR
                                                    : ccs_pkg::MODE_BLOCK;
            end
            ccs_pkg::MODE_STAR:
            begin
                if (b == ccs_pkg::CH_SLASH)
                    mode_step = ccs_pkg::MODE_NORMAL;
                else if (b == ccs_pkg::CH_STAR)
                    mode_step = ccs_pkg::MODE_STAR;
                else
                    mode_step = ccs_pkg::MODE_BLOCK;
            end
            default:
            begin
                mode_step = (b == ccs_pkg::CH_SLASH) ? ccs_pkg::MODE_SLASH
                                                     : ccs_pkg::MODE_NORMAL;
            end
        endcase
        mode_next = src_data.in_last ? ccs_pkg::MODE_NORMAL : mode_step;
    end

    always_comb
    begin
        result = '0;
        unique case (mode_reg)
            ccs_pkg::MODE_SLASH:
            begin
                if (b != ccs_pkg::CH_SLASH && b != ccs_pkg::CH_STAR)
                begin
                    result.count            = 2'd2;
                    result.item0.out_byte   = ccs_pkg::CH_SLASH;
                    result.item0.byte_valid = 1'b1;
                    result.item1.out_byte   = b;
                    result.item1.byte_valid = 1'b1;
                end
            end
            ccs_pkg::MODE_LINE, ccs_pkg::MODE_BLOCK, ccs_pkg::MODE_STAR:
            begin
                result.count = 2'd0;
            end
            default:
            begin
                if (b != ccs_pkg::CH_SLASH)
                begin
                    result.count            = 2'd1;
                    result.item0.out_byte   = b;
                    result.item0.byte_valid = 1'b1;
                end
            end
        endcase
        if (src_data.in_last)
        begin
            if (result.count == 2'd2)
            begin
                result.item1.out_last = 1'b1;
            end
            else if (result.count == 2'd1)
            begin
                result.item0.out_last = 1'b1;
            end
            else
            begin
                // A slash held at the end of the text is sent as a plain byte.
                result.count          = 2'd1;
                result.item0.out_last = 1'b1;
                if (mode_step == ccs_pkg::MODE_SLASH)
                begin
                    result.item0.out_byte   = ccs_pkg::CH_SLASH;
                    result.item0.byte_valid = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= ccs_pkg::MODE_NORMAL;
        end
        else if (src_xfer)
        begin
            mode_reg <= mode_next;
        end
    end

    ccs_out_queue #(
        .Depth(Depth)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (src_xfer),
        .push_data (result),
        .room      (room),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_data  (dst_data)
    );

    a_last_resets_mode: assert property (@(posedge clk) disable iff (!rst_n)
        src_xfer && src_data.in_last |=> mode_reg == ccs_pkg::MODE_NORMAL)
        else $error("scan mode not cleared after the last byte");

    a_result_shows: assert property (@(posedge clk) disable iff (!rst_n)
        src_xfer && result.count != 2'd0 |=> dst_valid)
        else $error("result of an accepted byte not offered");

    a_stall_needs_data: assert property (@(posedge clk) disable iff (!rst_n)
        src_stall |-> dst_valid)
        else $error("input stalled while the result queue is empty");

    a_last_flag_once: assert property (@(posedge clk) disable iff (!rst_n)
        src_xfer && result.count == 2'd2 |-> !result.item0.out_last)
        else $error("end mark placed on the first of two results");

endmodule
